@@ rtl/pgsc_pkg.sv @@
// Shared constants, types and a helper function of the polar goal steering controller.
`default_nettype none

package pgsc_pkg;

   // Angles are in 1/4096 rad.
   localparam int ANG_PI     = 12868;
   localparam int ANG_2PI    = 25736;
   localparam int PI_Q20     = 3294199;
   localparam int MAX_STAGES = 24;
   localparam int SQRT_STEPS = 17;

   // Working widths of the arctangent and square root datapaths.
   localparam int XY_W  = 28;
   localparam int Z_W   = 25;
   localparam int SQ_W  = 34;
   localparam int RHO_W = 17;

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0]  z_type;
   typedef logic [SQ_W-1:0]        sq_type;

   // Arctangent of 2^-i in Q20 radians.
   localparam logic [19:0] ATAN_Q20 [MAX_STAGES] = '{
      20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
      20'd16383,  20'd8192,   20'd4096,   20'd2048,   20'd1024,  20'd512,
      20'd256,    20'd128,    20'd64,     20'd32,     20'd16,    20'd8,
      20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
   };

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_GOAL_X         = 3'd0,
      REG_GOAL_Y         = 3'd1,
      REG_GOAL_HEADING   = 3'd2,
      REG_LIN_GAIN       = 3'd3,
      REG_ANG_GAIN_ALPHA = 3'd4,
      REG_ANG_GAIN_BETA  = 3'd5,
      REG_POS_TOLERANCE  = 3'd6,
      REG_ANG_TOLERANCE  = 3'd7
   } reg_index_type;

   // Per-item data that travels beside the arithmetic units.
   typedef struct packed {
      logic signed [14:0] heading;
      logic               arrived;
   } side_type;

   // Brings an angle into (-pi, pi] with at most two corrections.
   function automatic logic signed [16:0] wrap_angle(input logic signed [16:0] a);
      logic signed [16:0] t;
      t = a;
      for (int k = 0; k < 2; k++) begin
         if (t > 17'(ANG_PI)) begin
            t = t - 17'(ANG_2PI);
         end else if (t <= -17'(ANG_PI)) begin
            t = t + 17'(ANG_2PI);
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pgsc_req_if.sv @@
// Channel interfaces for pose requests and steering responses.
`default_nettype none

interface pgsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pose_x;
   logic signed [15:0] pose_y;
   logic signed [15:0] pose_heading;
   modport source (output valid, pose_x, pose_y, pose_heading, input ready);
   modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface pgsc_rsp_if;
   logic               valid;
   logic               ready;
   logic [14:0]        linear_velocity;
   logic signed [14:0] angular_velocity;
   logic               arrived;
   modport source (output valid, linear_velocity, angular_velocity, arrived, input ready);
   modport sink (input valid, linear_velocity, angular_velocity, arrived, output ready);
endinterface

`default_nettype wire

@@ rtl/pgsc_cordic.sv @@
// Pipelined vectoring CORDIC that yields the bearing angle in Q20 radians.
`default_nettype none

module pgsc_cordic #(
   parameter int ITERS = 16,
   parameter int DEPTH = 17
) (
   input  wire                  clock,
   input  wire                  enable,
   input  pgsc_pkg::xy_type     x_start,
   input  pgsc_pkg::xy_type     y_start,
   input  pgsc_pkg::z_type      z_start,
   input  wire                  zero_start,
   output pgsc_pkg::z_type      z_result,
   output logic                 zero_result
);
   import pgsc_pkg::*;

   xy_type x_ff [DEPTH];
   xy_type y_ff [DEPTH];
   z_type  z_ff [DEPTH];
   logic   zero_ff [DEPTH];
   xy_type x_in [DEPTH];
   xy_type y_in [DEPTH];
   z_type  z_in [DEPTH];
   logic   zero_in [DEPTH];

   for (genvar s = 0; s < DEPTH; s++) begin : g_stage
      xy_type xp, yp;
      z_type  zp;
      logic   zerop;

      // Stage input comes from the unit input or the previous stage.
      always_comb begin
         if (s == 0) begin
            xp = x_start;
            yp = y_start;
            zp = z_start;
            zerop = zero_start;
         end else begin
            xp = x_ff[s-1];
            yp = y_ff[s-1];
            zp = z_ff[s-1];
            zerop = zero_ff[s-1];
         end
      end

      // One micro-rotation toward the x axis, or a plain pass once iterations are done.
      always_comb begin
         zero_in[s] = zerop;
         if (s < ITERS) begin
            if (yp >= 0) begin
               x_in[s] = xp + (yp >>> s);
               y_in[s] = yp - (xp >>> s);
               z_in[s] = zp + z_type'(ATAN_Q20[s]);
            end else begin
               x_in[s] = xp - (yp >>> s);
               y_in[s] = yp + (xp >>> s);
               z_in[s] = zp - z_type'(ATAN_Q20[s]);
            end
         end else begin
            x_in[s] = xp;
            y_in[s] = yp;
            z_in[s] = zp;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[s] <= x_in[s];
            y_ff[s] <= y_in[s];
            z_ff[s] <= z_in[s];
            zero_ff[s] <= zero_in[s];
         end
      end
   end

   assign z_result = z_ff[DEPTH-1];
   assign zero_result = zero_ff[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/pgsc_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module pgsc_isqrt #(
   parameter int DEPTH = 17
) (
   input  wire                         clock,
   input  wire                         enable,
   input  pgsc_pkg::sq_type            radicand,
   output logic [pgsc_pkg::RHO_W-1:0]  root
);
   import pgsc_pkg::*;

   sq_type v_ff [DEPTH];
   sq_type r_ff [DEPTH];
   sq_type v_in [DEPTH];
   sq_type r_in [DEPTH];

   for (genvar s = 0; s < DEPTH; s++) begin : g_stage
      sq_type vp, rp;
      localparam int SHIFT = (s < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - s) : 0;
      localparam sq_type BIT = sq_type'(1) << SHIFT;

      always_comb begin
         if (s == 0) begin
            vp = radicand;
            rp = '0;
         end else begin
            vp = v_ff[s-1];
            rp = r_ff[s-1];
         end
      end

      // Trial subtraction of the current bit pair.
      always_comb begin
         if (s < SQRT_STEPS) begin
            if (vp >= rp + BIT) begin
               v_in[s] = vp - (rp + BIT);
               r_in[s] = (rp >> 1) + BIT;
            end else begin
               v_in[s] = vp;
               r_in[s] = rp >> 1;
            end
         end else begin
            v_in[s] = vp;
            r_in[s] = rp;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            v_ff[s] <= v_in[s];
            r_ff[s] <= r_in[s];
         end
      end
   end

   assign root = r_ff[DEPTH-1][RHO_W-1:0];

endmodule

`default_nettype wire

@@ rtl/polar_goal_steering_controller_core.sv @@
// Top level of the polar goal steering controller: registers, pipeline control and math.
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        pose_x, pose_y, pose_heading
//   rsp      out        valid/ready        linear_velocity, angular_velocity, arrived
//   csr      in         APB write/read     eight goal, gain and tolerance registers
//
// One pose is taken each cycle the pipeline advances; it passes stages 0 to 2, the CORDIC
// and 17-step square root of DEPTH = max(CORDIC_STAGES, 17) stages, then A, B and output.
// The whole pipeline advances together whenever the output register is empty or taken,
// so a stall on rsp holds every stage and nothing is lost or repeated.
// Reset is synchronous: it clears all valid bits and loads register defaults.
`default_nettype none

module polar_goal_steering_controller_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire          clock,
   input  wire          reset,
   pgsc_req_if.sink     req_chan,
   pgsc_rsp_if.source   rsp_chan,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [4:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import pgsc_pkg::*;

   localparam int DEPTH = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
   localparam int SIDE_N = DEPTH + 3;
   localparam int OUT_IX = DEPTH + 5;

   // Configuration registers.
   logic signed [15:0] goal_x_ff, goal_y_ff, gain_a_ff, gain_b_ff;
   logic signed [14:0] goal_h_ff;
   logic [14:0]        lin_gain_ff, pos_tol_ff, ang_tol_ff;
   reg_index_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_index = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         goal_h_ff <= '0;
         lin_gain_ff <= 15'd1229;
         gain_a_ff <= 16'sd3277;
         gain_b_ff <= -16'sd614;
         pos_tol_ff <= 15'd26;
         ang_tol_ff <= 15'd4096;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index)
            REG_GOAL_X:         goal_x_ff <= csr_pwdata[15:0];
            REG_GOAL_Y:         goal_y_ff <= csr_pwdata[15:0];
            REG_GOAL_HEADING:   goal_h_ff <= csr_pwdata[14:0];
            REG_LIN_GAIN:       lin_gain_ff <= csr_pwdata[14:0];
            REG_ANG_GAIN_ALPHA: gain_a_ff <= csr_pwdata[15:0];
            REG_ANG_GAIN_BETA:  gain_b_ff <= csr_pwdata[15:0];
            REG_POS_TOLERANCE:  pos_tol_ff <= csr_pwdata[14:0];
            REG_ANG_TOLERANCE:  ang_tol_ff <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Register read back, signed registers sign-extended.
   always_comb begin
      case (csr_index)
         REG_GOAL_X:         csr_prdata = 32'(goal_x_ff);
         REG_GOAL_Y:         csr_prdata = 32'(goal_y_ff);
         REG_GOAL_HEADING:   csr_prdata = 32'(goal_h_ff);
         REG_LIN_GAIN:       csr_prdata = {17'd0, lin_gain_ff};
         REG_ANG_GAIN_ALPHA: csr_prdata = 32'(gain_a_ff);
         REG_ANG_GAIN_BETA:  csr_prdata = 32'(gain_b_ff);
         REG_POS_TOLERANCE:  csr_prdata = {17'd0, pos_tol_ff};
         REG_ANG_TOLERANCE:  csr_prdata = {17'd0, ang_tol_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // Pipeline advance: every stage moves when the output register is free or taken.
   logic               enable;
   logic [OUT_IX:0]    vld_ff;

   assign enable = !vld_ff[OUT_IX] || rsp_chan.ready;
   assign req_chan.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[OUT_IX-1:0], req_chan.valid};
      end
   end

   // Stage 0: errors, heading wrap and arrival test.
   logic signed [16:0] dx_in, dy_in, hw_full, hdiff, dx_abs, dy_abs, hd_abs;
   logic signed [16:0] dx_ff, dy_ff;
   side_type           side_in;
   side_type           side_ff [SIDE_N];

   always_comb begin
      dx_in = 17'(goal_x_ff) - 17'(req_chan.pose_x);
      dy_in = 17'(goal_y_ff) - 17'(req_chan.pose_y);
      hw_full = 17'(req_chan.pose_heading);
      if (hw_full > 17'(ANG_PI)) begin
         hw_full = hw_full - 17'(ANG_2PI);
      end else if (hw_full < -17'(ANG_PI)) begin
         hw_full = hw_full + 17'(ANG_2PI);
      end
      hdiff = 17'(goal_h_ff) - hw_full;
      dx_abs = (dx_in < 0) ? -dx_in : dx_in;
      dy_abs = (dy_in < 0) ? -dy_in : dy_in;
      hd_abs = (hdiff < 0) ? -hdiff : hdiff;
      side_in.heading = hw_full[14:0];
      side_in.arrived = (dx_abs < $signed({2'b00, pos_tol_ff}))
                     && (dy_abs < $signed({2'b00, pos_tol_ff}))
                     && (hd_abs < $signed({2'b00, ang_tol_ff}));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         side_ff[0] <= side_in;
         for (int i = 1; i < SIDE_N; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Stage 1: squares of the errors.
   sq_type             sqx_ff, sqy_ff;
   logic signed [16:0] dx1_ff, dy1_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sqx_ff <= sq_type'(SQ_W'(dx_ff) * SQ_W'(dx_ff));
         sqy_ff <= sq_type'(SQ_W'(dy_ff) * SQ_W'(dy_ff));
         dx1_ff <= dx_ff;
         dy1_ff <= dy_ff;
      end
   end

   // Stage 2: radicand sum and CORDIC start vector with the half-plane fold.
   sq_type  sum_ff;
   xy_type  cx_ff, cy_ff, cx_in, cy_in;
   z_type   cz_ff, cz_in;
   logic    czero_ff;

   always_comb begin
      cx_in = xy_type'(dx1_ff) <<< 8;
      cy_in = xy_type'(dy1_ff) <<< 8;
      cz_in = '0;
      if (dx1_ff < 0) begin
         cz_in = (dy1_ff >= 0) ? z_type'(PI_Q20) : -z_type'(PI_Q20);
         cx_in = -cx_in;
         cy_in = -cy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sqx_ff + sqy_ff;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         czero_ff <= (dx1_ff == 0) && (dy1_ff == 0);
      end
   end

   // Arithmetic units of equal depth.
   z_type             z_res;
   logic              zero_res;
   logic [RHO_W-1:0]  rho_res;

   pgsc_cordic #(
      .ITERS (CORDIC_STAGES),
      .DEPTH (DEPTH)
   ) u_cordic (
      .clock       (clock),
      .enable      (enable),
      .x_start     (cx_ff),
      .y_start     (cy_ff),
      .z_start     (cz_ff),
      .zero_start  (czero_ff),
      .z_result    (z_res),
      .zero_result (zero_res)
   );

   pgsc_isqrt #(
      .DEPTH (DEPTH)
   ) u_isqrt (
      .clock    (clock),
      .enable   (enable),
      .radicand (sum_ff),
      .root     (rho_res)
   );

   // Stage A: bearing rounding and clamp, alpha and beta wrap.
   z_type              z_rnd;
   logic signed [16:0] bearing, alpha_full, beta_full;
   logic signed [14:0] alpha_ff, beta_ff;
   logic [RHO_W-1:0]   rho_ff;
   logic               arr_a_ff;
   side_type           side_u;

   assign side_u = side_ff[SIDE_N-1];

   always_comb begin
      z_rnd = (z_res + z_type'(128)) >>> 8;
      if (zero_res) begin
         bearing = '0;
      end else if (z_rnd > z_type'(ANG_PI)) begin
         bearing = 17'(ANG_PI);
      end else if (z_rnd < -z_type'(ANG_PI)) begin
         bearing = -17'(ANG_PI);
      end else begin
         bearing = z_rnd[16:0];
      end
      alpha_full = wrap_angle(bearing - 17'(side_u.heading));
      beta_full = wrap_angle(17'(goal_h_ff) - 17'(side_u.heading));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         alpha_ff <= alpha_full[14:0];
         beta_ff <= beta_full[14:0];
         rho_ff <= rho_res;
         arr_a_ff <= side_u.arrived;
      end
   end

   // Stage B: gain products.
   logic [31:0]        pv_ff;
   logic signed [31:0] pwa_ff, pwb_ff;
   logic               arr_b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         pv_ff <= 32'(lin_gain_ff) * 32'(rho_ff);
         pwa_ff <= 32'(gain_a_ff) * 32'(alpha_ff);
         pwb_ff <= 32'(gain_b_ff) * 32'(beta_ff);
         arr_b_ff <= arr_a_ff;
      end
   end

   // Output stage: rounding, saturation and arrival override.
   logic [32:0]        v_sum, v_q;
   logic signed [32:0] w_sum, w_q;
   logic [14:0]        lin_ff, lin_in;
   logic signed [14:0] ang_ff, ang_in;
   logic               arr_ff;

   always_comb begin
      v_sum = 33'(pv_ff) + 33'd2048;
      v_q = v_sum >> 12;
      w_sum = 33'(pwa_ff) + 33'(pwb_ff) + 33'sd2048;
      w_q = w_sum >>> 12;
      lin_in = (v_q > 33'd32767) ? 15'h7FFF : v_q[14:0];
      if (w_q > 33'sd16383) begin
         ang_in = 15'sd16383;
      end else if (w_q < -33'sd16384) begin
         ang_in = -15'sd16384;
      end else begin
         ang_in = w_q[14:0];
      end
      if (arr_b_ff) begin
         lin_in = '0;
         ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lin_ff <= lin_in;
         ang_ff <= ang_in;
         arr_ff <= arr_b_ff;
      end
   end

   assign rsp_chan.valid = vld_ff[OUT_IX];
   assign rsp_chan.linear_velocity = lin_ff;
   assign rsp_chan.angular_velocity = ang_ff;
   assign rsp_chan.arrived = arr_ff;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench of the polar goal steering controller core.
`default_nettype none

module tb_top;
   import pgsc_pkg::*;

   localparam int LATENCY     = 17 + 6;
   localparam int CYCLE_LIMIT = 400000;

   // A 5-bit address reaches eight 32-bit registers at 4*i.
   typedef struct packed {
      logic [14:0]        lin;
      logic signed [14:0] ang;
      logic               arr;
   } steer_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pgsc_req_if req_chan ();
   pgsc_rsp_if rsp_chan ();

   polar_goal_steering_controller_core dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow copy of the configuration registers.
   longint g_x, g_y, g_head, k_lin, k_alpha, k_beta, tol_pos, tol_ang;

   steer_type steer_queue[$];
   int  errors;
   int  cycles = 0;
   bit  quiet;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle counter with a hard limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint bearing(longint dy, longint dx);
      longint x, y, z, nx;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (dx < 0) begin
         z = (dy >= 0) ? PI_Q20 : -PI_Q20;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z = z + ATAN_Q20[i];
         end else begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z = z - ATAN_Q20[i];
         end
         x = nx;
      end
      z = floor_shift(z + 128, 8);
      if (z > ANG_PI) z = ANG_PI;
      if (z < -ANG_PI) z = -ANG_PI;
      return z;
   endfunction

   function automatic longint fold_angle(longint a);
      for (int k = 0; k < 2; k++) begin
         if (a > ANG_PI) a = a - ANG_2PI;
         else if (a <= -ANG_PI) a = a + ANG_2PI;
      end
      return a;
   endfunction

   function automatic steer_type steer_command(logic signed [15:0] px,
                                               logic signed [15:0] py,
                                               logic signed [15:0] ph);
      steer_type r;
      longint h, dx, dy, rho, alpha, beta, v, w;
      h = ph;
      if (h > ANG_PI) h = h - ANG_2PI;
      else if (h < -ANG_PI) h = h + ANG_2PI;
      dx = g_x - px;
      dy = g_y - py;
      r = '0;
      if (mag(dx) < tol_pos && mag(dy) < tol_pos && mag(g_head - h) < tol_ang) begin
         r.arr = 1'b1;
         return r;
      end
      rho = int_sqrt(dx * dx + dy * dy);
      alpha = fold_angle(bearing(dy, dx) - h);
      beta = fold_angle(g_head - h);
      v = floor_shift(k_lin * rho + 2048, 12);
      if (v > 32767) v = 32767;
      if (v < 0) v = 0;
      w = floor_shift(k_alpha * alpha + k_beta * beta + 2048, 12);
      if (w > 16383) w = 16383;
      if (w < -16384) w = -16384;
      r.lin = v[14:0];
      r.ang = w[14:0];
      return r;
   endfunction

   // Random stall on the response side; none once the run goes quiet.
   initial begin
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 4);
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Compare each response transfer with the oldest prediction.
   always @(posedge clock) begin
      steer_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.linear_velocity, rsp_chan.angular_velocity, rsp_chan.arrived};
         if (steer_queue.size() == 0) begin
            $display("%0t unexpected response: actual %h", $time, got);
            errors++;
         end else begin
            want = steer_queue.pop_front();
            if (got.lin !== want.lin)
               $display("%0t linear_velocity: expected %0d actual %0d",
                        $time, want.lin, got.lin);
            if (got.ang !== want.ang)
               $display("%0t angular_velocity: expected %0d actual %0d",
                        $time, want.ang, got.ang);
            if (got.arr !== want.arr)
               $display("%0t arrived: expected %0d actual %0d", $time, want.arr, got.arr);
            if (got !== want) errors++;
         end
      end
   end

   // One pose transfer, with an optional random gap in front.
   task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] ph);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.pose_x       <= px;
      req_chan.pose_y       <= py;
      req_chan.pose_heading <= ph;
      do @(posedge clock); while (!req_chan.ready);
      steer_queue.push_back(steer_command(px, py, ph));
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (steer_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // Return to idle between register writes.
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_GOAL_X:         g_x = longint'($signed(value[15:0]));
         REG_GOAL_Y:         g_y = longint'($signed(value[15:0]));
         REG_GOAL_HEADING:   g_head = longint'($signed(value[14:0]));
         REG_LIN_GAIN:       k_lin = value[14:0];
         REG_ANG_GAIN_ALPHA: k_alpha = longint'($signed(value[15:0]));
         REG_ANG_GAIN_BETA:  k_beta = longint'($signed(value[15:0]));
         REG_POS_TOLERANCE:  tol_pos = value[14:0];
         REG_ANG_TOLERANCE:  tol_ang = value[14:0];
         default: ;
      endcase
   endtask

   task automatic write_all(longint gx, longint gy, longint gh, longint kl,
                            longint ka, longint kb, longint tp, longint ta);
      write_reg(REG_GOAL_X, 32'(gx));
      write_reg(REG_GOAL_Y, 32'(gy));
      write_reg(REG_GOAL_HEADING, 32'(gh));
      write_reg(REG_LIN_GAIN, 32'(kl));
      write_reg(REG_ANG_GAIN_ALPHA, 32'(ka));
      write_reg(REG_ANG_GAIN_BETA, 32'(kb));
      write_reg(REG_POS_TOLERANCE, 32'(tp));
      write_reg(REG_ANG_TOLERANCE, 32'(ta));
   endtask

   function automatic logic signed [15:0] rand_heading();
      return 16'($urandom_range(0, 2 * 25736) - 25736);
   endfunction

   // Extremes of the pose fields, wrap boundaries, zero vector and arrival.
   task automatic test_directed();
      send_pose(0, 0, 0);
      send_pose(0, 0, 16'sd5000);
      send_pose(16'sd10, -16'sd10, 16'sd100);
      send_pose(16'sd26, 0, 0);
      send_pose(0, 0, 16'sd4096);
      send_pose(-16'sd32768, -16'sd32768, -16'sd25736);
      send_pose(16'sd32767, 16'sd32767, 16'sd25736);
      send_pose(16'sd32767, -16'sd32768, 16'sd12868);
      send_pose(-16'sd32768, 16'sd32767, -16'sd12868);
      send_pose(16'sd256, 0, 16'sd12869);
      send_pose(0, 16'sd256, -16'sd12869);
      send_pose(16'sd256, 0, 16'sd32767);
      send_pose(0, -16'sd256, -16'sd32768);
      send_pose(16'sd100, 16'sd0, -16'sd1);
      send_pose(16'sd100, -16'sd1, 16'sd0);
      send_pose(-16'sd500, 16'sd300, 16'sd7000);
      send_pose(16'sd500, 16'sd300, -16'sd7000);
      wait_idle();
   endtask

   // Random poses: half near the goal, half across the whole range.
   task automatic test_random(int count);
      logic signed [15:0] px, py, ph;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               px = 16'(g_x + $urandom_range(0, 80) - 40);
               py = 16'(g_y + $urandom_range(0, 80) - 40);
               ph = 16'(g_head + $urandom_range(0, 8000) - 4000);
            end
            1: begin
               px = 16'(g_x + $urandom_range(0, 4000) - 2000);
               py = 16'(g_y + $urandom_range(0, 4000) - 2000);
               ph = rand_heading();
            end
            2: begin
               px = 16'($urandom);
               py = 16'($urandom);
               ph = 16'($urandom);
            end
            default: begin
               px = 16'($urandom);
               py = 16'($urandom);
               ph = rand_heading();
            end
         endcase
         send_pose(px, py, ph);
      end
      wait_idle();
   endtask

   // Configuration extremes and random settings.
   task automatic test_settings();
      write_all(32767, -32768, 12868, 32767, 32767, -32768, 32767, 25736);
      test_random(150);
      write_all(-32768, 32767, -12868, 0, -32768, 32767, 0, 0);
      test_random(150);
      for (int s = 0; s < 6; s++) begin
         write_all($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 25736) - 12868, $urandom_range(0, 32767),
                   $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 300), $urandom_range(0, 25736));
         test_random(150);
      end
   endtask

   initial begin
      errors = 0;
      quiet  = 1'b0;
      g_x = 0; g_y = 0; g_head = 0;
      k_lin = 1229; k_alpha = 3277; k_beta = -614;
      tol_pos = 26; tol_ang = 4096;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.pose_x = '0; req_chan.pose_y = '0; req_chan.pose_heading = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (LATENCY + 4) @(posedge clock);
      test_directed();
      test_random(200);
      test_settings();
      // Closing stretch with no stalls on either side.
      write_all(256, -512, 3000, 1229, 3277, -614, 26, 4096);
      quiet = 1'b1;
      test_random(150);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/pgsc_pkg.sv
rtl/pgsc_req_if.sv
rtl/pgsc_cordic.sv
rtl/pgsc_isqrt.sv
rtl/polar_goal_steering_controller_core.sv
verif/tb_top.sv
